>>> rtl/core/mm3_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 x64_128 core.
package mm3_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int CNT_W = 5;
	localparam int ADDR_W = 4;

	localparam logic [CNT_W-1:0] BLOCK_BYTES = 5'd16;

	// Register map: 64-bit registers at 8-byte spacing, selected by address bit 3
	localparam logic REG_SEED_LOW = 1'b0;
	localparam logic REG_SEED_HIGH = 1'b1;

	localparam logic [WORD_W-1:0] MIX_C1 = 64'h87c37b91114253d5;
	localparam logic [WORD_W-1:0] MIX_C2 = 64'h4cf5ad432745937f;
	localparam logic [WORD_W-1:0] ADD_ONE = 64'h0000000052dce729;
	localparam logic [WORD_W-1:0] ADD_TWO = 64'h0000000038495ab5;
	localparam logic [WORD_W-1:0] FIN_M1 = 64'hff51afd7ed558ccd;
	localparam logic [WORD_W-1:0] FIN_M2 = 64'hc4ceb9fe1a85ec53;

	// Request to the shared multiplier
	typedef struct packed {
		logic start;
		logic [WORD_W-1:0] op_a;
		logic [WORD_W-1:0] op_b;
	} mul_req_t;

	// Keeps the low n bytes of a word; n of 8 or more keeps all
	function automatic logic [WORD_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
		logic [WORD_W-1:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (n > CNT_W'(i)) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [WORD_W-1:0] rotl31(input logic [WORD_W-1:0] x);
		return {x[32:0], x[63:33]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl27(input logic [WORD_W-1:0] x);
		return {x[36:0], x[63:37]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl33(input logic [WORD_W-1:0] x);
		return {x[30:0], x[63:31]};
	endfunction

	function automatic logic [WORD_W-1:0] fold33(input logic [WORD_W-1:0] x);
		return x ^ (x >> 33);
	endfunction

endpackage

>>> rtl/core/mm3_mul.sv
// Shared 64x64 multiplier, low 64 product bits, one 32x32 partial product per cycle.
module mm3_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mm3_pkg::mul_req_t          req,
	output logic                       done,
	output logic [mm3_pkg::WORD_W-1:0] product
);

	typedef enum logic [1:0] {
		STEP_IDLE,
		STEP_LL,
		STEP_LH,
		STEP_HL
	} step_t;

	step_t step_q;
	logic done_q;
	logic [mm3_pkg::WORD_W-1:0] a_q;
	logic [mm3_pkg::WORD_W-1:0] b_q;
	logic [mm3_pkg::WORD_W-1:0] acc_q;
	logic [mm3_pkg::HALF_W-1:0] ma;
	logic [mm3_pkg::HALF_W-1:0] mb;
	logic [mm3_pkg::WORD_W-1:0] mp;

	always_comb begin
		case (step_q)
			STEP_LH: begin
				ma = a_q[31:0];
				mb = b_q[63:32];
			end
			STEP_HL: begin
				ma = a_q[63:32];
				mb = b_q[31:0];
			end
			default: begin
				ma = a_q[31:0];
				mb = b_q[31:0];
			end
		endcase
		mp = mm3_pkg::WORD_W'(ma) * mm3_pkg::WORD_W'(mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			done_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				STEP_IDLE: begin
					if (req.start) begin
						a_q <= req.op_a;
						b_q <= req.op_b;
						step_q <= STEP_LL;
					end
				end
				STEP_LL: begin
					acc_q <= mp;
					step_q <= STEP_LH;
				end
				STEP_LH: begin
					// cross terms only reach the upper half
					acc_q[63:32] <= acc_q[63:32] + mp[31:0];
					step_q <= STEP_HL;
				end
				STEP_HL: begin
					acc_q[63:32] <= acc_q[63:32] + mp[31:0];
					done_q <= 1'b1;
					step_q <= STEP_IDLE;
				end
				default: step_q <= STEP_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign product = acc_q;

endmodule

>>> rtl/core/murmur3_x64_128_hash.sv
// MurmurHash3 x64_128 top level: APB seeds, block sequencer and hash state.
// Non-last block: four 64-bit multiplies with the H1 and H2 steps, from transfer to ready again.
// Last block: mixing (a partial tail skips H1 and H2), then FIN0 to FIN5 until the result is shown.
// Every multiply runs on one 32x32 multiplier as three partial products; that unit sets the rate.
// One block in flight; a held result does not stop the next block from entering.
// Reset (arst_n low) clears seeds, hash state, length and any open message.
module murmur3_x64_128_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mm3_pkg::ADDR_W-1:0]  paddr,
	input  logic [mm3_pkg::WORD_W-1:0]  pwdata,
	output logic [mm3_pkg::WORD_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        blk_valid,
	output logic                        blk_ready,
	input  logic [mm3_pkg::WORD_W-1:0]  word_low,
	input  logic [mm3_pkg::WORD_W-1:0]  word_high,
	input  logic [mm3_pkg::CNT_W-1:0]   byte_count,
	input  logic                        last_block,
	output logic                        hash_valid,
	input  logic                        hash_ready,
	output logic [mm3_pkg::WORD_W-1:0]  hash_low,
	output logic [mm3_pkg::WORD_W-1:0]  hash_high
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M1,
		ST_M2,
		ST_H1,
		ST_M3,
		ST_M4,
		ST_H2,
		ST_FIN0,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_FA1,
		ST_FA2,
		ST_FB1,
		ST_FB2,
		ST_FIN4,
		ST_FIN5
	} state_t;

	state_t state_q;
	logic issued_q;
	logic tail_q;
	logic last_q;
	logic open_q;
	logic hash_valid_q;
	logic [mm3_pkg::WORD_W-1:0] seed_low_q;
	logic [mm3_pkg::WORD_W-1:0] seed_high_q;
	logic [mm3_pkg::WORD_W-1:0] h1_q;
	logic [mm3_pkg::WORD_W-1:0] h2_q;
	logic [mm3_pkg::WORD_W-1:0] len_q;
	logic [mm3_pkg::WORD_W-1:0] k_q;
	logic [mm3_pkg::WORD_W-1:0] lo_q;
	logic [mm3_pkg::WORD_W-1:0] hi_q;
	logic [mm3_pkg::WORD_W-1:0] hash_low_q;
	logic [mm3_pkg::WORD_W-1:0] hash_high_q;

	mm3_pkg::mul_req_t mul_req;
	logic mul_done;
	logic [mm3_pkg::WORD_W-1:0] mul_p;

	logic cfg_wr;
	logic [mm3_pkg::CNT_W-1:0] cnt_eff;
	logic partial;
	logic [mm3_pkg::WORD_W-1:0] len_base;
	logic [mm3_pkg::WORD_W-1:0] h1_base;
	logic [mm3_pkg::WORD_W-1:0] h2_base;
	logic [mm3_pkg::WORD_W-1:0] lo_in;
	logic [mm3_pkg::WORD_W-1:0] hi_in;
	logic out_free;
	logic mul_state;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == mm3_pkg::REG_SEED_HIGH) ? seed_high_q : seed_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q <= '0;
			seed_high_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == mm3_pkg::REG_SEED_HIGH) begin
				seed_high_q <= pwdata;
			end else begin
				seed_low_q <= pwdata;
			end
		end
	end

	// ---------------- input decode ----------------
	always_comb begin
		cnt_eff = (byte_count > mm3_pkg::BLOCK_BYTES) ? mm3_pkg::BLOCK_BYTES : byte_count;
		partial = last_block && (cnt_eff != mm3_pkg::BLOCK_BYTES);
		len_base = open_q ? len_q : '0;
		h1_base = open_q ? h1_q : seed_low_q;
		h2_base = open_q ? h2_q : seed_high_q;
		lo_in = word_low;
		hi_in = word_high;
		if (partial) begin
			lo_in = word_low & mm3_pkg::byte_mask(cnt_eff);
			hi_in = (cnt_eff > 5'd8) ? (word_high & mm3_pkg::byte_mask(cnt_eff - 5'd8)) : '0;
		end
	end

	assign blk_ready = (state_q == ST_IDLE);
	assign out_free = !hash_valid_q || hash_ready;

	// ---------------- shared multiplier ----------------
	assign mul_state = (state_q == ST_M1) || (state_q == ST_M2) || (state_q == ST_M3)
		|| (state_q == ST_M4) || (state_q == ST_FA1) || (state_q == ST_FA2)
		|| (state_q == ST_FB1) || (state_q == ST_FB2);

	always_comb begin
		mul_req.start = mul_state && !issued_q;
		case (state_q)
			ST_M1: begin
				mul_req.op_a = lo_q;
				mul_req.op_b = mm3_pkg::MIX_C1;
			end
			ST_M2: begin
				mul_req.op_a = k_q;
				mul_req.op_b = mm3_pkg::MIX_C2;
			end
			ST_M3: begin
				mul_req.op_a = hi_q;
				mul_req.op_b = mm3_pkg::MIX_C2;
			end
			ST_M4: begin
				mul_req.op_a = k_q;
				mul_req.op_b = mm3_pkg::MIX_C1;
			end
			ST_FA1: begin
				mul_req.op_a = h1_q;
				mul_req.op_b = mm3_pkg::FIN_M1;
			end
			ST_FA2: begin
				mul_req.op_a = h1_q;
				mul_req.op_b = mm3_pkg::FIN_M2;
			end
			ST_FB1: begin
				mul_req.op_a = h2_q;
				mul_req.op_b = mm3_pkg::FIN_M1;
			end
			ST_FB2: begin
				mul_req.op_a = h2_q;
				mul_req.op_b = mm3_pkg::FIN_M2;
			end
			default: begin
				mul_req.op_a = k_q;
				mul_req.op_b = mm3_pkg::MIX_C1;
			end
		endcase
	end

	mm3_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_p)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			tail_q <= 1'b0;
			last_q <= 1'b0;
			open_q <= 1'b0;
			hash_valid_q <= 1'b0;
			h1_q <= '0;
			h2_q <= '0;
			len_q <= '0;
			k_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			hash_low_q <= '0;
			hash_high_q <= '0;
		end else begin
			if (hash_valid_q && hash_ready) begin
				hash_valid_q <= 1'b0;
			end
			if (mul_req.start) begin
				issued_q <= 1'b1;
			end
			if (mul_done) begin
				issued_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (blk_valid) begin
						h1_q <= h1_base;
						h2_q <= h2_base;
						len_q <= len_base + (last_block ? 64'(cnt_eff) : 64'(mm3_pkg::BLOCK_BYTES));
						open_q <= 1'b1;
						lo_q <= lo_in;
						hi_q <= hi_in;
						last_q <= last_block;
						tail_q <= partial;
						// a partial tail mixes the high half first, then the low half
						state_q <= partial ? ST_M3 : ST_M1;
					end
				end
				ST_M1: begin
					if (mul_done) begin
						k_q <= mm3_pkg::rotl31(mul_p);
						state_q <= ST_M2;
					end
				end
				ST_M2: begin
					if (mul_done) begin
						if (tail_q) begin
							h1_q <= h1_q ^ mul_p;
							state_q <= ST_FIN0;
						end else begin
							h1_q <= mm3_pkg::rotl27(h1_q ^ mul_p) + h2_q;
							state_q <= ST_H1;
						end
					end
				end
				ST_H1: begin
					h1_q <= (h1_q << 2) + h1_q + mm3_pkg::ADD_ONE;
					state_q <= ST_M3;
				end
				ST_M3: begin
					if (mul_done) begin
						k_q <= mm3_pkg::rotl33(mul_p);
						state_q <= ST_M4;
					end
				end
				ST_M4: begin
					if (mul_done) begin
						if (tail_q) begin
							h2_q <= h2_q ^ mul_p;
							state_q <= ST_M1;
						end else begin
							h2_q <= mm3_pkg::rotl31(h2_q ^ mul_p) + h1_q;
							state_q <= ST_H2;
						end
					end
				end
				ST_H2: begin
					h2_q <= (h2_q << 2) + h2_q + mm3_pkg::ADD_TWO;
					// full last block: the tail is empty, go straight to finalization
					state_q <= last_q ? ST_FIN0 : ST_IDLE;
				end
				ST_FIN0: begin
					h1_q <= h1_q ^ len_q;
					h2_q <= h2_q ^ len_q;
					state_q <= ST_FIN1;
				end
				ST_FIN1: begin
					h1_q <= h1_q + h2_q;
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					h2_q <= h2_q + h1_q;
					state_q <= ST_FIN3;
				end
				ST_FIN3: begin
					h1_q <= mm3_pkg::fold33(h1_q);
					h2_q <= mm3_pkg::fold33(h2_q);
					state_q <= ST_FA1;
				end
				ST_FA1: begin
					if (mul_done) begin
						h1_q <= mm3_pkg::fold33(mul_p);
						state_q <= ST_FA2;
					end
				end
				ST_FA2: begin
					if (mul_done) begin
						h1_q <= mm3_pkg::fold33(mul_p);
						state_q <= ST_FB1;
					end
				end
				ST_FB1: begin
					if (mul_done) begin
						h2_q <= mm3_pkg::fold33(mul_p);
						state_q <= ST_FB2;
					end
				end
				ST_FB2: begin
					if (mul_done) begin
						h2_q <= mm3_pkg::fold33(mul_p);
						state_q <= ST_FIN4;
					end
				end
				ST_FIN4: begin
					h1_q <= h1_q + h2_q;
					state_q <= ST_FIN5;
				end
				ST_FIN5: begin
					if (out_free) begin
						hash_low_q <= h1_q;
						hash_high_q <= h2_q + h1_q;
						h2_q <= h2_q + h1_q;
						hash_valid_q <= 1'b1;
						open_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign hash_valid = hash_valid_q;
	assign hash_low = hash_low_q;
	assign hash_high = hash_high_q;

	// ---------------- assertions ----------------
	a_mul_latency: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> ##4 mul_done)
		else $error("multiplier result not back four cycles after launch");

	a_idle_no_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !issued_q)
		else $error("multiply still outstanding while idle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash_valid_q) |-> $past(state_q == ST_FIN5))
		else $error("result raised outside the final step");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_valid && blk_ready) |=> !blk_ready)
		else $error("new block taken while one is in progress");

endmodule

>>> tb/tb_murmur3_x64_128_hash.sv
// Self-checking testbench for the MurmurHash3 x64_128 block hasher.
`timescale 1ns / 100ps

module tb_murmur3_x64_128_hash;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 800;

	localparam logic [63:0] K_MUL1 = 64'h87c37b91114253d5;
	localparam logic [63:0] K_MUL2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] K_ADD1 = 64'h0000000052dce729;
	localparam logic [63:0] K_ADD2 = 64'h0000000038495ab5;
	localparam logic [63:0] K_FIN1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] K_FIN2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] ALL_ONES = {64{1'b1}};

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
	} digest_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [mm3_pkg::ADDR_W-1:0]  paddr;
	logic [mm3_pkg::WORD_W-1:0]  pwdata;
	logic [mm3_pkg::WORD_W-1:0]  prdata;
	logic                        pready;
	logic                        blk_valid;
	logic                        blk_ready;
	logic [mm3_pkg::WORD_W-1:0]  word_low;
	logic [mm3_pkg::WORD_W-1:0]  word_high;
	logic [mm3_pkg::CNT_W-1:0]   byte_count;
	logic                        last_block;
	logic                        hash_valid;
	logic                        hash_ready;
	logic [mm3_pkg::WORD_W-1:0]  hash_low;
	logic [mm3_pkg::WORD_W-1:0]  hash_high;

	// hasher state mirror
	logic [63:0] seed_lo_m;
	logic [63:0] seed_hi_m;
	logic [63:0] acc_one;
	logic [63:0] acc_two;
	logic [63:0] msg_bytes;
	bit          msg_open;

	digest_t digest_q[$];
	digest_t digest_got;
	int      err_count;
	int      cycle_count;
	int      in_idle_max;
	int      out_idle_max;

	murmur3_x64_128_hash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.blk_valid  (blk_valid),
		.blk_ready  (blk_ready),
		.word_low   (word_low),
		.word_high  (word_high),
		.byte_count (byte_count),
		.last_block (last_block),
		.hash_valid (hash_valid),
		.hash_ready (hash_ready),
		.hash_low   (hash_low),
		.hash_high  (hash_high)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		err_count++;
		$display("%0t ERROR: %s", $time, msg);
	endtask

	function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
		return (v << r) | (v >> (64 - r));
	endfunction

	function automatic logic [63:0] fmix64(input logic [63:0] v);
		v = v ^ (v >> 33);
		v = v * K_FIN1;
		v = v ^ (v >> 33);
		v = v * K_FIN2;
		v = v ^ (v >> 33);
		return v;
	endfunction

	function automatic logic [63:0] scramble_lo(input logic [63:0] k);
		return rotl(k * K_MUL1, 31) * K_MUL2;
	endfunction

	function automatic logic [63:0] scramble_hi(input logic [63:0] k);
		return rotl(k * K_MUL2, 33) * K_MUL1;
	endfunction

	function automatic logic [63:0] low_bytes(input logic [63:0] v, input int n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++)
			if (i < n)
				m[8*i +: 8] = 8'hff;
		return v & m;
	endfunction

	function automatic logic [63:0] rand_word();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return ALL_ONES;
		return {$urandom, $urandom};
	endfunction

	task automatic mix_block(input logic [63:0] lo, input logic [63:0] hi);
		acc_one = acc_one ^ scramble_lo(lo);
		acc_one = rotl(acc_one, 27) + acc_two;
		acc_one = acc_one * 5 + K_ADD1;
		acc_two = acc_two ^ scramble_hi(hi);
		acc_two = rotl(acc_two, 31) + acc_one;
		acc_two = acc_two * 5 + K_ADD2;
	endtask

	// Advance the hash state by one accepted block; queue a digest on the last one
	task automatic absorb_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt, input logic is_last);
		int n;
		logic [63:0] a;
		logic [63:0] b;
		digest_t d;
		if (!msg_open) begin
			acc_one = seed_lo_m;
			acc_two = seed_hi_m;
			msg_bytes = '0;
			msg_open = 1'b1;
		end
		if (!is_last) begin
			mix_block(lo, hi);
			msg_bytes += 64'd16;
			return;
		end
		n = (cnt > 5'd16) ? 16 : int'(cnt);
		msg_bytes += 64'(n);
		if (n == 16) begin
			mix_block(lo, hi);
		end else begin
			if (n > 8)
				acc_two = acc_two ^ scramble_hi(low_bytes(hi, n - 8));
			if (n > 0)
				acc_one = acc_one ^ scramble_lo(low_bytes(lo, n));
		end
		a = acc_one ^ msg_bytes;
		b = acc_two ^ msg_bytes;
		a = a + b;
		b = b + a;
		a = fmix64(a);
		b = fmix64(b);
		a = a + b;
		b = b + a;
		acc_one = a;
		acc_two = b;
		msg_open = 1'b0;
		d.lo = a;
		d.hi = b;
		digest_q.push_back(d);
	endtask

	// Sends one block; valid stays high after the transfer so a zero gap runs back to back
	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt, input logic is_last);
		int gap;
		gap = $urandom_range(0, in_idle_max);
		if (gap != 0) begin
			blk_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blk_valid <= 1'b1;
		word_low <= lo;
		word_high <= hi;
		byte_count <= cnt;
		last_block <= is_last;
		do
			@(posedge clk);
		while (!(blk_valid && blk_ready));
		absorb_block(lo, hi, cnt, is_last);
	endtask

	task automatic wait_idle();
		blk_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		// a body block may still be in the multiplier with nothing queued
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register
	task automatic write_seed(input logic sel, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (sel == mm3_pkg::REG_SEED_LOW)
			seed_lo_m = val;
		else
			seed_hi_m = val;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== val)
			report_error($sformatf("seed reg %0d read 0x%016h, wrote 0x%016h",
				sel, prdata, val));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_seeds(input logic [63:0] lo, input logic [63:0] hi);
		wait_idle();
		write_seed(mm3_pkg::REG_SEED_LOW, lo);
		write_seed(mm3_pkg::REG_SEED_HIGH, hi);
	endtask

	// Result side: stall is counted from the cycle the digest shows up
	initial begin
		int hold;
		hash_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = $urandom_range(0, out_idle_max);
			if (hold != 0) begin
				hash_ready <= 1'b0;
				do
					@(posedge clk);
				while (!hash_valid);
				repeat (hold - 1) @(posedge clk);
			end
			hash_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(hash_valid && hash_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && hash_valid && hash_ready) begin
			if (digest_q.size() == 0) begin
				report_error($sformatf("unexpected digest 0x%016h_%016h",
					hash_high, hash_low));
			end else begin
				digest_got = digest_q.pop_front();
				if (hash_low !== digest_got.lo)
					report_error($sformatf("hash_low 0x%016h, expected 0x%016h",
						hash_low, digest_got.lo));
				if (hash_high !== digest_got.hi)
					report_error($sformatf("hash_high 0x%016h, expected 0x%016h",
						hash_high, digest_got.hi));
			end
		end
	end

	task automatic test_empty_message();
		send_block('0, '0, 5'd0, 1'b1);
		// bytes past the count must not matter
		send_block(ALL_ONES, ALL_ONES, 5'd0, 1'b1);
	endtask

	task automatic test_tail_sizes();
		logic [4:0] sizes[8];
		sizes = '{5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd31};
		foreach (sizes[i])
			send_block(rand_word(), rand_word(), sizes[i], 1'b1);
	endtask

	task automatic test_block_chain();
		// count is ignored on body blocks
		send_block(ALL_ONES, ALL_ONES, 5'd0, 1'b0);
		send_block('0, '0, 5'd31, 1'b0);
		send_block(rand_word(), rand_word(), 5'd16, 1'b1);
		send_block(rand_word(), rand_word(), 5'd5, 1'b0);
		send_block(rand_word(), rand_word(), 5'd9, 1'b1);
	endtask

	task automatic test_seed_settings();
		set_seeds(ALL_ONES, ALL_ONES);
		send_block('0, '0, 5'd0, 1'b1);
		send_block(rand_word(), rand_word(), 5'd3, 1'b1);
		set_seeds('0, ALL_ONES);
		send_block(rand_word(), rand_word(), 5'd12, 1'b1);
		set_seeds(ALL_ONES, '0);
		send_block(rand_word(), rand_word(), 5'd16, 1'b1);
	endtask

	task automatic test_seed_mid_message();
		set_seeds(rand_word(), rand_word());
		send_block(rand_word(), rand_word(), 5'd16, 1'b0);
		// new seeds apply only once this message has closed
		set_seeds(rand_word(), rand_word());
		send_block(rand_word(), rand_word(), 5'd12, 1'b1);
		send_block(rand_word(), rand_word(), 5'd0, 1'b1);
	endtask

	task automatic test_random_traffic(input int total);
		int sent;
		int nblk;
		int pick;
		logic [4:0] cnt;
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 3)
				set_seeds(ALL_ONES, '0);
			else
				set_seeds({$urandom, $urandom}, {$urandom, $urandom});
			case (phase)
				0: begin in_idle_max = 10; out_idle_max = 10; end
				1: begin in_idle_max = 0; out_idle_max = 0; end
				2: begin in_idle_max = 10; out_idle_max = 0; end
				default: begin in_idle_max = 0; out_idle_max = 10; end
			endcase
			sent = 0;
			while (sent < total / 4) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					nblk = $urandom_range(1, 4);
				else if (pick < 95)
					nblk = $urandom_range(5, 12);
				else
					nblk = $urandom_range(13, 40);
				for (int b = 1; b < nblk; b++)
					send_block(rand_word(), rand_word(), 5'($urandom_range(0, 31)), 1'b0);
				if ($urandom_range(0, 4) == 0)
					cnt = 5'($urandom_range(17, 31));
				else
					cnt = 5'($urandom_range(0, 16));
				send_block(rand_word(), rand_word(), cnt, 1'b1);
				sent += nblk;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		blk_valid = 1'b0;
		word_low = '0;
		word_high = '0;
		byte_count = '0;
		last_block = 1'b0;
		seed_lo_m = '0;
		seed_hi_m = '0;
		acc_one = '0;
		acc_two = '0;
		msg_bytes = '0;
		msg_open = 1'b0;
		err_count = 0;
		cycle_count = 0;
		in_idle_max = 10;
		out_idle_max = 10;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_message();
		test_tail_sizes();
		test_block_chain();
		test_seed_settings();
		test_seed_mid_message();
		test_random_traffic(RANDOM_ITEMS);

		wait_idle();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mm3_pkg.sv
rtl/core/mm3_mul.sv
rtl/core/murmur3_x64_128_hash.sv
tb/tb_murmur3_x64_128_hash.sv
